// ----- src/wjd_pkg.sv -----
package wjd_pkg;

  localparam int CompW  = 16;
  localparam int TripW  = 3 * CompW;
  localparam int StatW  = 2;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 16;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_COUPLING = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_SWEEPS   = 1'b1;

  localparam logic [StatW-1:0] ST_OK   = 2'd0;
  localparam logic [StatW-1:0] ST_ZERO = 2'd1;
  localparam logic [StatW-1:0] ST_SAT  = 2'd2;

  localparam logic [15:0] COUPLING_RST = 16'd0;
  localparam logic [7:0]  SWEEPS_RST   = 8'd20;

  typedef struct packed {
    logic               action;
    logic [7:0]         cell_index;
    logic signed [15:0] value_x;
    logic signed [15:0] value_y;
    logic signed [15:0] value_z;
    logic [15:0]        weight;
    logic               last_load;
  } in_t;

  typedef struct packed {
    logic signed [15:0] result_x;
    logic signed [15:0] result_y;
    logic signed [15:0] result_z;
    logic [1:0]         status;
  } out_t;

  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001,
    S_CLR     = 20'h00002,
    S_RD_ME   = 20'h00004,
    S_CHK     = 20'h00008,
    S_RD_NB   = 20'h00010,
    S_MUL_NB  = 20'h00020,
    S_ACC_NB  = 20'h00040,
    S_MUL_DEN = 20'h00080,
    S_ACC_DEN = 20'h00100,
    S_MUL_LO  = 20'h00200,
    S_ACC_LO  = 20'h00400,
    S_MUL_HI  = 20'h00800,
    S_ACC_HI  = 20'h01000,
    S_MUL_SW  = 20'h02000,
    S_ACC_SW  = 20'h04000,
    S_DIV_PRE = 20'h08000,
    S_DIV     = 20'h10000,
    S_DIV_END = 20'h20000,
    S_WR      = 20'h40000,
    S_NEXT    = 20'h80000
  } state_t;

  // Pick one component of a packed {x, y, z} triple.
  function automatic logic signed [CompW-1:0] comp_sel(input logic [TripW-1:0] v,
                                                       input logic [1:0] k);
    logic signed [CompW-1:0] r;
    case (k)
      2'd0:    r = v[47:32];
      2'd1:    r = v[31:16];
      default: r = v[15:0];
    endcase
    return r;
  endfunction

endpackage

// ----- src/weighted_jacobi_diffusion.sv -----
// Weighted Jacobi diffusion over a SIDE x SIDE grid of three-component Q8.8
// values. Each accepted beat is a load (stores source and Q4.12 weight) or a
// read (returns one result beat, all zero for an index off the grid). A read
// holds in_ready low while the buffer is fetched, and no further read is
// taken while its result beat waits on out_ready. After reset, a clearing
// pass zeroes both ping-pong buffers and the status store, with in_ready
// low. A load with last_load set starts a run: the same clearing pass, then
// sweep_count sweeps, each visiting every cell in turn on one shared 20x18
// multiplier and a one-bit-per-cycle divider. Each cell is fetched, its
// neighbors are accumulated, the divisor is formed, each component is
// divided and the result is written back before the raster advances; a cell
// of zero weight goes straight to write-back. The in_ready signal stays low
// throughout a run. Configuration writes are accepted at any time but belong
// in idle periods.
module weighted_jacobi_diffusion import wjd_pkg::*; #(
  parameter int SIDE = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_t                 in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_t                out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int CELLS = SIDE * SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(SIDE);

  // Configuration registers.
  logic [15:0] coupling_r;
  logic [7:0]  sweeps_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coupling_r <= COUPLING_RST;
      sweeps_r   <= SWEEPS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COUPLING: coupling_r <= cfg_data;
        CFG_SWEEPS:   sweeps_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer state.
  state_t state_r, state_nxt;
  logic [AW-1:0] me_r;
  logic [RW-1:0] row_r, col_r;
  logic [7:0]    sw_r;
  logic [1:0]    nb_r;
  logic [1:0]    j_r;
  logic [4:0]    cnt_r;
  logic          last_buf_r;
  logic          boot_r;
  logic          rd_pend_r, rd_oob_r;
  logic          out_valid_r;
  out_t          out_r;

  // Input decode.
  logic          in_acc, is_read, in_oob;
  logic [31:0]   idx_wide;
  logic [AW-1:0] in_addr;

  assign idx_wide = 32'(in_data.cell_index);
  assign in_addr  = idx_wide[AW-1:0];
  assign in_oob   = int'(in_data.cell_index) >= CELLS;
  assign is_read  = (in_data.action == ACT_READ);
  assign in_ready = (state_r == S_IDLE) && !rd_pend_r && (!is_read || !out_valid_r);
  assign in_acc   = in_valid && in_ready;

  logic last_cell;
  assign last_cell = (me_r == AW'(CELLS - 1));

  // Edge-clamped neighbor address: up, down, left, right.
  logic [AW-1:0] nb_addr;
  always_comb begin
    case (nb_r)
      2'd0:    nb_addr = (row_r == '0) ? me_r : me_r - AW'(SIDE);
      2'd1:    nb_addr = (row_r == RW'(SIDE - 1)) ? me_r : me_r + AW'(SIDE);
      2'd2:    nb_addr = (col_r == '0) ? me_r : me_r - AW'(1);
      default: nb_addr = (col_r == RW'(SIDE - 1)) ? me_r : me_r + AW'(1);
    endcase
  end

  // Memories.
  logic [TripW-1:0] src_mem  [CELLS];
  logic [15:0]      wt_mem   [CELLS];
  logic [TripW-1:0] even_mem [CELLS];
  logic [TripW-1:0] odd_mem  [CELLS];
  logic [StatW-1:0] stat_mem [CELLS];
  logic [TripW-1:0] src_q, even_q, odd_q;
  logic [15:0]      wt_q;
  logic [StatW-1:0] stat_q;

  logic load_wr;
  assign load_wr = in_acc && !is_read && !in_oob;

  always_ff @(posedge clk) begin
    if (load_wr) begin
      src_mem[in_addr] <= {in_data.value_x, in_data.value_y, in_data.value_z};
    end
    if (state_r == S_RD_ME) begin
      src_q <= src_mem[me_r];
    end
  end

  always_ff @(posedge clk) begin
    if (load_wr) begin
      wt_mem[in_addr] <= in_data.weight;
    end
    if (state_r == S_RD_ME) begin
      wt_q <= wt_mem[me_r];
    end else if (state_r == S_RD_NB) begin
      wt_q <= wt_mem[nb_addr];
    end
  end

  logic signed [15:0] res_r [3];
  logic               sat_r, zw_r;
  logic [TripW-1:0]   res_trip;
  logic               dst_odd;

  assign res_trip = {res_r[0], res_r[1], res_r[2]};
  assign dst_odd  = !sw_r[0];

  // Sweep reads the source buffer at the neighbor; idle reads serve read beats.
  logic [AW-1:0] buf_raddr;
  logic          buf_ren;
  assign buf_raddr = (state_r == S_RD_NB) ? nb_addr : in_addr;
  assign buf_ren   = (state_r == S_RD_NB) || (in_acc && is_read);

  always_ff @(posedge clk) begin
    if (state_r == S_CLR) begin
      even_mem[me_r] <= '0;
    end else if (state_r == S_WR && !dst_odd) begin
      even_mem[me_r] <= res_trip;
    end
    if (buf_ren) begin
      even_q <= even_mem[buf_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CLR) begin
      odd_mem[me_r] <= '0;
    end else if (state_r == S_WR && dst_odd) begin
      odd_mem[me_r] <= res_trip;
    end
    if (buf_ren) begin
      odd_q <= odd_mem[buf_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CLR) begin
      stat_mem[me_r] <= ST_OK;
    end else if (state_r == S_WR) begin
      stat_mem[me_r] <= zw_r ? ST_ZERO : (sat_r ? ST_SAT : ST_OK);
    end
    if (in_acc && is_read) begin
      stat_q <= stat_mem[in_addr];
    end
  end

  // Shared multiplier: signed 20 bits times unsigned 17 bits.
  logic [TripW-1:0]   nbbuf_q;
  logic [15:0]        w_me_r;
  logic [TripW-1:0]   src_me_r;
  logic signed [34:0] s_r [3];
  logic signed [19:0] mul_a;
  logic [16:0]        mul_b;
  logic signed [17:0] mul_bs;
  logic signed [37:0] prod_r;
  logic [18:0]        one4a;

  assign nbbuf_q = sw_r[0] ? odd_q : even_q;
  assign one4a   = 19'd256 + {1'b0, coupling_r, 2'b00};
  assign mul_bs  = $signed({1'b0, mul_b});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL_NB: begin
        mul_a = 20'(comp_sel(nbbuf_q, j_r));
        mul_b = {1'b0, wt_q};
      end
      S_MUL_DEN: begin
        mul_a = {1'b0, one4a};
        mul_b = {1'b0, w_me_r};
      end
      S_MUL_LO: begin
        mul_a = {3'b000, s_r[j_r][16:0]};
        mul_b = {1'b0, coupling_r};
      end
      S_MUL_HI: begin
        // upper half of the neighbor sum keeps its sign
        mul_a = 20'($signed(s_r[j_r][34:17]));
        mul_b = {1'b0, coupling_r};
      end
      S_MUL_SW: begin
        mul_a = 20'(comp_sel(src_me_r, j_r));
        mul_b = {1'b0, w_me_r};
      end
      default: ;
    endcase
  end

  // Divider datapath.
  logic signed [51:0] num_r;
  logic [34:0]        den_r;
  logic               neg_r, ovf_r;
  logic [35:0]        rem_r;
  logic [16:0]        xlo_r, q_r;
  logic [51:0]        mag, xdiv;
  logic [35:0]        trial;
  logic               fits;

  assign mag   = num_r[51] ? 52'(-num_r) : 52'(num_r);
  assign xdiv  = mag + {17'b0, den_r >> 1};
  assign trial = {rem_r[34:0], xlo_r[16]};
  assign fits  = trial >= {1'b0, den_r};

  logic signed [15:0] div_val;
  logic               div_sat;
  always_comb begin
    if (!neg_r) begin
      div_sat = ovf_r || (q_r > 17'd32767);
      div_val = div_sat ? 16'sd32767 : q_r[15:0];
    end else begin
      div_sat = ovf_r || (q_r > 17'd32768);
      div_val = div_sat ? 16'h8000 : 16'(-$signed({1'b0, q_r}));
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 38'(mul_a * mul_bs);
    case (state_r)
      S_CHK: begin
        w_me_r   <= wt_q;
        src_me_r <= src_q;
        sat_r    <= 1'b0;
        zw_r     <= (wt_q == '0);
        for (int i = 0; i < 3; i++) begin
          s_r[i]   <= '0;
          res_r[i] <= '0;
        end
      end
      S_ACC_NB:  s_r[j_r] <= s_r[j_r] + 35'(prod_r);
      S_ACC_DEN: den_r <= prod_r[34:0];
      S_ACC_LO:  num_r <= 52'(prod_r);
      S_ACC_HI:  num_r <= num_r + (52'(prod_r) <<< 17);
      S_ACC_SW:  num_r <= num_r + (52'(prod_r) <<< 8);
      S_DIV_PRE: begin
        neg_r <= num_r[51];
        ovf_r <= {1'b0, xdiv} >= {1'b0, den_r, 17'b0};
        rem_r <= 36'(xdiv[51:17]);
        xlo_r <= xdiv[16:0];
        q_r   <= '0;
      end
      S_DIV: begin
        rem_r <= fits ? trial - {1'b0, den_r} : trial;
        xlo_r <= {xlo_r[15:0], 1'b0};
        q_r   <= {q_r[15:0], fits};
      end
      S_DIV_END: begin
        res_r[j_r] <= div_val;
        sat_r      <= sat_r | div_sat;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_acc && !is_read && in_data.last_load) state_nxt = S_CLR;
      S_CLR: begin
        // the pass after reset only clears; a run goes on to its sweeps, if any
        if (last_cell) state_nxt = (boot_r || sweeps_r == '0) ? S_IDLE : S_RD_ME;
      end
      S_RD_ME:   state_nxt = S_CHK;
      S_CHK:     state_nxt = (wt_q == '0) ? S_WR : S_RD_NB;
      S_RD_NB:   state_nxt = S_MUL_NB;
      S_MUL_NB:  state_nxt = S_ACC_NB;
      S_ACC_NB: begin
        if (j_r != 2'd2) state_nxt = S_MUL_NB;
        else if (nb_r != 2'd3) state_nxt = S_RD_NB;
        else state_nxt = S_MUL_DEN;
      end
      S_MUL_DEN: state_nxt = S_ACC_DEN;
      S_ACC_DEN: state_nxt = S_MUL_LO;
      S_MUL_LO:  state_nxt = S_ACC_LO;
      S_ACC_LO:  state_nxt = S_MUL_HI;
      S_MUL_HI:  state_nxt = S_ACC_HI;
      S_ACC_HI:  state_nxt = S_MUL_SW;
      S_MUL_SW:  state_nxt = S_ACC_SW;
      S_ACC_SW:  state_nxt = S_DIV_PRE;
      S_DIV_PRE: state_nxt = S_DIV;
      S_DIV:     if (cnt_r == 5'd16) state_nxt = S_DIV_END;
      S_DIV_END: state_nxt = (j_r == 2'd2) ? S_WR : S_MUL_LO;
      S_WR:      state_nxt = S_NEXT;
      S_NEXT: begin
        if (last_cell && (sw_r + 8'd1 == sweeps_r)) state_nxt = S_IDLE;
        else state_nxt = S_RD_ME;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      boot_r     <= 1'b1;
      me_r       <= '0;
      row_r      <= '0;
      col_r      <= '0;
      sw_r       <= '0;
      nb_r       <= '0;
      j_r        <= '0;
      cnt_r      <= '0;
      last_buf_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          me_r  <= '0;
          row_r <= '0;
          col_r <= '0;
          sw_r  <= '0;
        end
        S_CLR: begin
          me_r <= last_cell ? '0 : me_r + AW'(1);
          if (last_cell) begin
            boot_r <= 1'b0;
          end
        end
        S_CHK: begin
          nb_r <= '0;
          j_r  <= '0;
        end
        S_ACC_NB: begin
          if (j_r != 2'd2) begin
            j_r <= j_r + 2'd1;
          end else begin
            j_r  <= '0;
            nb_r <= nb_r + 2'd1;
          end
        end
        S_DIV_PRE: cnt_r <= '0;
        S_DIV:     cnt_r <= cnt_r + 5'd1;
        S_DIV_END: j_r <= j_r + 2'd1;
        S_NEXT: begin
          // Advance the raster; wrap to the next sweep at the last cell.
          if (last_cell) begin
            me_r       <= '0;
            row_r      <= '0;
            col_r      <= '0;
            sw_r       <= sw_r + 8'd1;
            last_buf_r <= dst_odd;
          end else begin
            me_r <= me_r + AW'(1);
            if (col_r == RW'(SIDE - 1)) begin
              col_r <= '0;
              row_r <= row_r + RW'(1);
            end else begin
              col_r <= col_r + RW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Read beats: memory read, then the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= in_acc && is_read;
      if (rd_pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  logic [TripW-1:0] rd_trip;
  assign rd_trip = last_buf_r ? odd_q : even_q;

  always_ff @(posedge clk) begin
    if (in_acc && is_read) begin
      rd_oob_r <= in_oob;
    end
    if (rd_pend_r) begin
      if (rd_oob_r) begin
        out_r <= '0;
      end else begin
        out_r.result_x <= rd_trip[47:32];
        out_r.result_y <= rd_trip[31:16];
        out_r.result_z <= rd_trip[15:0];
        out_r.status   <= stat_q;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- test/tb_weighted_jacobi_diffusion.sv -----
`timescale 1ns / 1ps

module tb_weighted_jacobi_diffusion import wjd_pkg::*; ();

  localparam int SIDE  = 16;
  localparam int CELLS = SIDE * SIDE;
  // longest silent stretch: a full-grid run of 255 sweeps on zero weights
  // with one weighted cell; allow generous margin
  localparam int WATCHDOG_LIMIT = 1_500_000;
  localparam int ITEM_GOAL      = 1700;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_t                 in_data;
  logic                out_valid;
  logic                out_ready;
  out_t                out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  weighted_jacobi_diffusion #(.SIDE(SIDE)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Shadow of the grid: sources, weights, ping-pong buffers, cell status
  // ---------------------------------------------------------------------
  shortint     src_grid [CELLS][3];
  int          wt_grid  [CELLS];
  shortint     relax_buf[2][CELLS][3];
  logic [1:0]  cell_stat[CELLS];
  int          last_half;
  longint      coupling_q;
  int          sweeps_q;

  out_t pending_results[$];
  int   err_count;
  int   items_sent;
  bit   calm_tx, calm_rx, hold_go;
  int   hold_left;

  // Append one expected result beat.
  function automatic void queue_result(input out_t r);
    pending_results = {pending_results, r};
  endfunction

  // Round the Q.28 / Q.20 quotient to nearest, ties away from zero, then
  // clip to 16 bits; bit 16 of the return value flags clipping.
  function automatic logic [16:0] round_clip(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q   = (mag + den / 2) / den;
    if (num >= 0) begin
      if (q > 32767) return {1'b1, 16'sd32767};
      return {1'b0, q[15:0]};
    end
    if (q > 32768) return {1'b1, 16'h8000};
    q = -q;
    return {1'b0, q[15:0]};
  endfunction

  // One Jacobi pass from buffer half 'from' into the other half.
  task automatic relax_sweep(input int from);
    int      me, w;
    int      nb[4];
    longint  den, s, num;
    bit      sat;
    logic [16:0] rq;
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        me = r * SIDE + c;
        // clamp neighbours at the edges onto the cell itself
        nb[0] = ((r == 0) ? 0 : r - 1) * SIDE + c;
        nb[1] = ((r == SIDE - 1) ? SIDE - 1 : r + 1) * SIDE + c;
        nb[2] = r * SIDE + ((c == 0) ? 0 : c - 1);
        nb[3] = r * SIDE + ((c == SIDE - 1) ? SIDE - 1 : c + 1);
        w = wt_grid[me];
        if (w == 0) begin
          for (int k = 0; k < 3; k++) relax_buf[1 - from][me][k] = 0;
          cell_stat[me] = ST_ZERO;
          continue;
        end
        den = (256 + 4 * coupling_q) * longint'(w);
        sat = 1'b0;
        for (int k = 0; k < 3; k++) begin
          s = 0;
          for (int n = 0; n < 4; n++)
            s += longint'(relax_buf[from][nb[n]][k]) * longint'(wt_grid[nb[n]]);
          num = s * coupling_q + longint'(src_grid[me][k]) * longint'(w) * 256;
          rq  = round_clip(num, den);
          relax_buf[1 - from][me][k] = shortint'(rq[15:0]);
          sat |= rq[16];
        end
        cell_stat[me] = sat ? ST_SAT : ST_OK;
      end
    end
  endtask

  task automatic relax_run();
    for (int i = 0; i < CELLS; i++) begin
      cell_stat[i] = ST_OK;
      for (int k = 0; k < 3; k++) begin
        relax_buf[0][i][k] = 0;
        relax_buf[1][i][k] = 0;
      end
    end
    for (int k = 0; k < sweeps_q; k++) begin
      if (k % 2 == 0) begin
        relax_sweep(0);
        last_half = 1;
      end else begin
        relax_sweep(1);
        last_half = 0;
      end
    end
  endtask

  // Apply one accepted beat to the shadow grid; reads queue their result.
  task automatic grid_accept(input in_t b, input bit typed, input out_t want);
    out_t r;
    int   idx;
    idx = b.cell_index;
    if (b.action == ACT_LOAD) begin
      if (idx < CELLS) begin
        src_grid[idx][0] = b.value_x;
        src_grid[idx][1] = b.value_y;
        src_grid[idx][2] = b.value_z;
        wt_grid[idx]     = b.weight;
      end
      if (b.last_load) relax_run();
    end else begin
      if (idx >= CELLS) r = '0;
      else begin
        r.result_x = relax_buf[last_half][idx][0];
        r.result_y = relax_buf[last_half][idx][1];
        r.result_z = relax_buf[last_half][idx][2];
        r.status   = cell_stat[idx];
      end
      queue_result(typed ? want : r);
    end
  endtask

  // ---------------------------------------------------------------------
  // Drivers: inputs change on the falling edge, sampled on the rising one
  // ---------------------------------------------------------------------
  task automatic send_beat(input in_t b, input bit typed = 1'b0, input out_t want = '0);
    // insert random idle cycles unless in a calm stretch
    while (!calm_tx && $urandom_range(99) < 12) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = b;
    do @(posedge clk); while (!in_ready);
    grid_accept(b, typed, want);
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_COUPLING) coupling_q = val;
    else sweeps_q = val[7:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hold the sender until every queued result has come back.
  task automatic wait_results_done();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic in_t load_beat(int idx, int x, int y, int z, int w, bit last);
    in_t b;
    b.action     = ACT_LOAD;
    b.cell_index = 8'(idx);
    b.value_x    = 16'(x);
    b.value_y    = 16'(y);
    b.value_z    = 16'(z);
    b.weight     = 16'(w);
    b.last_load  = last;
    return b;
  endfunction

  function automatic in_t read_beat(int idx, bit last);
    in_t b;
    b = in_t'(74'({$urandom, $urandom, $urandom}));
    b.action     = ACT_READ;
    b.cell_index = 8'(idx);
    b.last_load  = last;
    return b;
  endfunction

  function automatic in_t random_load(bit last);
    in_t b;
    b = in_t'(74'({$urandom, $urandom, $urandom}));
    b.action    = ACT_LOAD;
    b.last_load = last;
    case ($urandom_range(9))
      0: b.weight = 16'd0;
      1: b.weight = 16'hFFFF;
      2: b.weight = 16'd1;
      default: ;
    endcase
    if ($urandom_range(7) == 0) b.value_x = 16'sh7FFF;
    if ($urandom_range(7) == 0) b.value_y = 16'sh8000;
    return b;
  endfunction

  // Write every cell so no run ever touches an unwritten source or weight.
  task automatic fill_grid(input bit zero_weights);
    in_t b;
    for (int i = 0; i < CELLS; i++) begin
      b = random_load(1'b0);
      b.cell_index = 8'(i);
      if (zero_weights) b.weight = 16'd0;
      send_beat(b);
    end
  endtask

  // ---------------------------------------------------------------------
  // Directed stimulus table
  // ---------------------------------------------------------------------
  typedef enum {ROW_BEAT, ROW_REG, ROW_FILL} row_kind_t;
  typedef struct {
    row_kind_t           kind;
    in_t                 beat;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [15:0]         reg_val;
    bit                  typed;
    out_t                want;
  } stim_row_t;

  stim_row_t stim_rows[$];

  // Append one row to the stimulus table.
  function automatic void add_row(input stim_row_t r);
    stim_rows = {stim_rows, r};
  endfunction

  function automatic stim_row_t beat_row(in_t b);
    stim_row_t r;
    r.kind = ROW_BEAT; r.beat = b; r.reg_idx = '0; r.reg_val = '0;
    r.typed = 1'b0; r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t read_row(int idx, int x, int y, int z, logic [1:0] st);
    stim_row_t r;
    r = beat_row(read_beat(idx, 1'b0));
    r.typed = 1'b1;
    r.want  = '{result_x: 16'(x), result_y: 16'(y), result_z: 16'(z), status: st};
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [CfgIdxW-1:0] idx, int val);
    stim_row_t r;
    r = beat_row('0);
    r.kind = ROW_REG; r.reg_idx = idx; r.reg_val = 16'(val);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", out_data);
        err_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_data.result_x !== e.result_x) begin
          $error("result_x expected %0d got %0d", e.result_x, out_data.result_x);
          err_count++;
        end
        if (out_data.result_y !== e.result_y) begin
          $error("result_y expected %0d got %0d", e.result_y, out_data.result_y);
          err_count++;
        end
        if (out_data.result_z !== e.result_z) begin
          $error("result_z expected %0d got %0d", e.result_z, out_data.result_z);
          err_count++;
        end
        if (out_data.status !== e.status) begin
          $error("status expected %0d got %0d", e.status, out_data.status);
          err_count++;
        end
      end
    end
  end

  // Receiver: random stalls, calm stretches, and one long hold-off.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_left = 400;
        hold_go   = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = calm_rx || ($urandom_range(99) >= 12);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int    round, n;
    in_t   b;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    rst_n      = 1'b0;
    calm_tx    = 1'b0;
    calm_rx    = 1'b0;
    hold_go    = 1'b0;
    hold_left  = 0;
    err_count  = 0;
    items_sent = 0;
    coupling_q = COUPLING_RST;
    sweeps_q   = SWEEPS_RST;
    last_half  = 0;
    for (int i = 0; i < CELLS; i++) begin
      wt_grid[i] = 0;
      cell_stat[i] = ST_OK;
      for (int k = 0; k < 3; k++) begin
        src_grid[i][k] = 0;
        relax_buf[0][i][k] = 0;
        relax_buf[1][i][k] = 0;
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // after reset cells 0 and 255 read back zero
    add_row(read_row(0, 0, 0, 0, ST_OK));
    add_row(read_row(255, 0, 0, 0, ST_OK));
    add_row(reg_row(CFG_COUPLING, 0));
    add_row(reg_row(CFG_SWEEPS, 1));
    add_row('{kind: ROW_FILL, beat: '0, reg_idx: '0, reg_val: '0,
              typed: 1'b0, want: '0});
    // zero coupling, one sweep: each weighted cell returns its own source exactly; a zero-weight cell reads zero
    add_row(beat_row(load_beat(0, 32767, -32768, 0, 16'hFFFF, 1'b0)));
    add_row(beat_row(load_beat(17, -1, 5, -7, 0, 1'b0)));
    add_row(beat_row(load_beat(255, -32768, 32767, -1, 1, 1'b1)));
    add_row(read_row(0, 32767, -32768, 0, ST_OK));
    add_row(read_row(17, 0, 0, 0, ST_ZERO));
    add_row(read_row(255, -32768, 32767, -1, ST_OK));
    // heavy neighbours around a light cell drive the second sweep into clipping
    add_row(reg_row(CFG_COUPLING, 256));
    add_row(reg_row(CFG_SWEEPS, 2));
    add_row(beat_row(load_beat(18, 32767, -32768, 32767, 16'hFFFF, 1'b0)));
    add_row(beat_row(load_beat(50, 32767, -32768, 32767, 16'hFFFF, 1'b0)));
    add_row(beat_row(load_beat(33, 32767, -32768, 32767, 16'hFFFF, 1'b0)));
    add_row(beat_row(load_beat(35, 32767, -32768, 32767, 16'hFFFF, 1'b0)));
    add_row(beat_row(load_beat(34, 0, 0, 0, 1, 1'b1)));
    add_row(beat_row(read_beat(34, 1'b0)));
    // a read carrying last_load must not start a run
    add_row(beat_row(read_beat(18, 1'b1)));
    add_row(beat_row(read_beat(0, 1'b0)));
    // zero sweeps: buffers and status cleared, reads give zero
    add_row(reg_row(CFG_SWEEPS, 0));
    add_row(beat_row(load_beat(1, 100, -100, 3, 16'h1000, 1'b1)));
    add_row(read_row(34, 0, 0, 0, ST_OK));
    add_row(read_row(0, 0, 0, 0, ST_OK));

    foreach (stim_rows[i]) begin
      case (stim_rows[i].kind)
        ROW_BEAT: send_beat(stim_rows[i].beat, stim_rows[i].typed, stim_rows[i].want);
        ROW_REG: begin
          wait_results_done();
          write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
        end
        default: fill_grid(1'b0);
      endcase
    end

    // Random rounds: reconfigure while idle, a burst of loads and reads,
    // then a run and a read that only lands once the run is over.
    round = 0;
    while (items_sent < ITEM_GOAL) begin
      wait_results_done();
      calm_tx = (round == 3);
      calm_rx = (round == 3);
      if (round == 5) begin
        // extreme settings: zero weights keep a 255-sweep run affordable
        write_reg(CFG_COUPLING, 16'hFFFF);
        write_reg(CFG_SWEEPS, 16'd255);
        fill_grid(1'b1);
        send_beat(random_load(1'b1));
        for (int i = 0; i < 8; i++) send_beat(read_beat(int'($urandom_range(CELLS - 1)), 1'b0));
        wait_results_done();
        fill_grid(1'b0);
        wait_results_done();
      end
      case ($urandom_range(2))
        0: write_reg(CFG_COUPLING, 16'd0);
        1: write_reg(CFG_COUPLING, 16'hFFFF);
        default: write_reg(CFG_COUPLING, 16'($urandom_range(16'hFFFF)));
      endcase
      n = int'($urandom_range(9));
      write_reg(CFG_SWEEPS, (n == 0) ? 16'd0 : (n < 3) ? 16'd2 : 16'd1);

      if (round == 2) begin
        // stall the receiver long enough to back the block up
        hold_go = 1'b1;
        for (int i = 0; i < 60; i++) send_beat(read_beat(int'($urandom_range(CELLS - 1)), 1'b0));
      end
      n = int'($urandom_range(90, 150));
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(9) < 7)
          b = read_beat(int'($urandom_range(CELLS - 1)), 1'($urandom_range(1)));
        else b = random_load(1'b0);
        send_beat(b);
      end
      send_beat(random_load(1'b1));
      send_beat(read_beat(int'($urandom_range(CELLS - 1)), 1'b0));
      round++;
    end

    calm_tx = 1'b0;
    calm_rx = 1'b0;
    wait_results_done();
    repeat (20) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
